// ===== hdl/arseg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package arseg_pkg;

	// display format selector
	typedef enum logic [1:0] {
		ACT_PLAIN = 2'd0,
		ACT_SPEED = 2'd1,
		ACT_TIME  = 2'd2,
		ACT_SPARE = 2'd3
	} action_t;

	localparam int unsigned VALUE_W = 24;
	localparam int unsigned SEG_W   = 8;
	localparam int unsigned CONV_W  = 20;            // binary bits fed to the BCD shifter
	localparam int unsigned BCD_W   = 24;            // six decimal digits
	localparam int unsigned DD_W    = BCD_W + CONV_W;

	// divide by ten: (v * ceil(2^27 / 10)) >> 27 is exact for all 24-bit v
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 24'd13421773;
	localparam int unsigned        RECIP_SHIFT = 27;

	localparam logic [VALUE_W-1:0] PLAIN_LIMIT = 24'd9999;
	localparam logic [VALUE_W-1:0] FIXED_LIMIT = 24'd1000000;
	localparam logic [VALUE_W-1:0] TEN_THOU    = 24'd10000;
	localparam logic [VALUE_W-1:0] HUND_THOU   = 24'd100000;

	localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
	localparam int unsigned      SEG_DOT_BIT = 4;

	// control word riding along the pipe
	typedef struct packed {
		logic       plain;
		logic       is_time;
		logic       over;
		logic [1:0] shift;
		logic [2:0] used;
	} ctrl_t;

	// active-low digit patterns
	function automatic logic [SEG_W-1:0] digit_code(input logic [3:0] d);
		logic [SEG_W-1:0] c;
		case (d)
			4'd0: c = 8'h14;
			4'd1: c = 8'h77;
			4'd2: c = 8'h1A;
			4'd3: c = 8'h52;
			4'd4: c = 8'h71;
			4'd5: c = 8'hD0;
			4'd6: c = 8'h90;
			4'd7: c = 8'h76;
			4'd8: c = 8'h10;
			4'd9: c = 8'h50;
			default: c = SEG_BLANK;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/arseg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface arseg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [23:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

interface arseg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] seg_rightmost;
	logic [7:0] seg_second;
	logic [7:0] seg_third;
	logic [7:0] seg_leftmost;

	modport source (output valid, output seg_rightmost, output seg_second,
		output seg_third, output seg_leftmost, input ready);
	modport sink   (input valid, input seg_rightmost, input seg_second,
		input seg_third, input seg_leftmost, output ready);
endinterface

`default_nettype wire

// ===== hdl/autorange_number_to_segments_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: a word taken into s1 moves on through s2, s3 and s4 and is presented on
// out_ch from the output register (five register stages).
// Throughput: one word per cycle unless out_ch stalls; the shift-add-3 BCD chain,
// cut over three stages, is the deepest path, with the /10 multiplier in the first stage.
// Stalls: the whole pipe holds while the output word waits.
// Reset: arst_n clears all stage valid bits at once; payload is not reset.
module autorange_number_to_segments_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	arseg_in_if.sink   in_ch,
	arseg_out_if.source out_ch
);
	import arseg_pkg::*;

	// one shift-add-3 step over {bcd, binary}
	function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
		logic [DD_W-1:0] y;
		y = x;
		for (int i = 0; i < BCD_W / 4; i++) begin
			if (y[CONV_W + 4*i +: 4] >= 4'd5)
				y[CONV_W + 4*i +: 4] = y[CONV_W + 4*i +: 4] + 4'd3;
		end
		return {y[DD_W-2:0], 1'b0};
	endfunction

	// whole pipe moves together; output register frees as soon as it is taken
	logic adv;
	assign adv         = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = adv;

	// ---------------- stage 1: capture, multiply by reciprocal of ten
	logic                   v_s1;
	logic [1:0]             act_s1;
	logic [VALUE_W-1:0]     value_s1;
	logic [2*VALUE_W-1:0]   prod_s1;

	// ---------------- stage 2: pick n, range flags, first BCD steps
	logic                   v_s2;
	ctrl_t                  ctrl_s2;
	logic [DD_W-1:0]        dd_s2;

	logic [VALUE_W-1:0]     n_c;
	ctrl_t                  ctrl_c;
	logic [DD_W-1:0]        dd2_c;

	always_comb begin
		logic [DD_W-1:0] x;
		// quotient fits well inside the product's top bits
		if (act_s1 == ACT_TIME)
			n_c = VALUE_W'(prod_s1[2*VALUE_W-1:RECIP_SHIFT]);
		else
			n_c = value_s1;

		ctrl_c.plain   = !(act_s1 == ACT_SPEED || act_s1 == ACT_TIME);
		ctrl_c.is_time = (act_s1 == ACT_TIME);
		ctrl_c.over    = ctrl_c.plain ? (value_s1 > PLAIN_LIMIT) : (n_c >= FIXED_LIMIT);
		// fixed modes: how far the shown digits move up
		if (n_c >= HUND_THOU)
			ctrl_c.shift = 2'd2;
		else if (n_c >= TEN_THOU)
			ctrl_c.shift = 2'd1;
		else
			ctrl_c.shift = 2'd0;
		// plain mode: count of lit digits
		if (value_s1 >= 24'd1000)
			ctrl_c.used = 3'd4;
		else if (value_s1 >= 24'd100)
			ctrl_c.used = 3'd3;
		else if (value_s1 >= 24'd10)
			ctrl_c.used = 3'd2;
		else
			ctrl_c.used = 3'd1;

		// overflowed values are replaced later, low bits are enough here
		x = {{BCD_W{1'b0}}, n_c[CONV_W-1:0]};
		for (int k = 0; k < 7; k++)
			x = dd_step(x);
		dd2_c = x;
	end

	// ---------------- stage 3 and 4: remaining BCD steps (7 + 6)
	logic                   v_s3;
	ctrl_t                  ctrl_s3;
	logic [DD_W-1:0]        dd_s3;
	logic                   v_s4;
	ctrl_t                  ctrl_s4;
	logic [DD_W-1:0]        dd_s4;

	logic [DD_W-1:0]        dd3_c;
	logic [DD_W-1:0]        dd4_c;

	always_comb begin
		logic [DD_W-1:0] x;
		x = dd_s2;
		for (int k = 0; k < 7; k++)
			x = dd_step(x);
		dd3_c = x;
	end

	always_comb begin
		logic [DD_W-1:0] x;
		x = dd_s3;
		for (int k = 0; k < 6; k++)
			x = dd_step(x);
		dd4_c = x;
	end

	// ---------------- stage 5: segment formatting into the output register
	logic [3:0][SEG_W-1:0]  seg_c;

	always_comb begin
		logic [BCD_W-1:0] bcd;
		logic [BCD_W-1:0] sh_bcd;
		logic [1:0]       dot;
		bcd    = dd_s4[DD_W-1:CONV_W];
		sh_bcd = bcd >> {ctrl_s4.shift, 2'b00};
		dot    = (ctrl_s4.is_time ? 2'd2 : 2'd3) - ctrl_s4.shift;
		for (int i = 0; i < 4; i++) begin
			if (ctrl_s4.plain) begin
				if (ctrl_s4.over)
					seg_c[i] = digit_code(4'd9);
				else if (i < int'(ctrl_s4.used))
					seg_c[i] = digit_code(bcd[4*i +: 4]);
				else
					seg_c[i] = SEG_BLANK;
			end else begin
				if (ctrl_s4.over)
					seg_c[i] = digit_code(4'd0);
				else begin
					seg_c[i] = digit_code(sh_bcd[4*i +: 4]);
					if (dot == 2'(i))
						seg_c[i][SEG_DOT_BIT] = 1'b0;
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			out_ch.valid <= 1'b0;
		end else if (adv) begin
			v_s1         <= in_ch.valid;
			v_s2         <= v_s1;
			v_s3         <= v_s2;
			v_s4         <= v_s3;
			out_ch.valid <= v_s4;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1   <= in_ch.action;
			value_s1 <= in_ch.value;
			prod_s1  <= {{VALUE_W{1'b0}}, in_ch.value} * {{VALUE_W{1'b0}}, RECIP_TEN};
			ctrl_s2  <= ctrl_c;
			dd_s2    <= dd2_c;
			ctrl_s3  <= ctrl_s2;
			dd_s3    <= dd3_c;
			ctrl_s4  <= ctrl_s3;
			dd_s4    <= dd4_c;
			out_ch.seg_rightmost <= seg_c[0];
			out_ch.seg_second    <= seg_c[1];
			out_ch.seg_third     <= seg_c[2];
			out_ch.seg_leftmost  <= seg_c[3];
		end
	end

endmodule

`default_nettype wire

// ===== verif/autorange_number_to_segments_unit_tb.sv =====
`timescale 1ns / 1ps

module autorange_number_to_segments_unit_tb;

	import arseg_pkg::*;

	// run shape
	localparam int RAND_WORDS     = 625;
	localparam int TAIL_WORDS     = 80;      // last words run with no idling
	localparam int SQUEEZE_AT     = 300;     // words sent before the long sink hold-off
	localparam int SQUEEZE_CYCLES = 60;
	localparam int DRAIN_CYCLES   = 20;      // pipe is five deep
	localparam int CYCLE_LIMIT    = 200000;
	localparam int REPORT_MAX     = 10;

	// own digit patterns, digit 0 in the low byte
	localparam logic [79:0] DIGIT_SEGS = {
		8'h50, 8'h10, 8'h76, 8'h90, 8'hD0, 8'h71, 8'h52, 8'h1A, 8'h77, 8'h14
	};

	// one output word, leftmost digit in the top byte
	typedef struct packed {
		logic [7:0] leftmost;
		logic [7:0] third;
		logic [7:0] second;
		logic [7:0] rightmost;
	} segs_t;

	// directed stimulus row: known answer where has_exp is set
	typedef struct {
		action_t     act;
		logic [23:0] val;
		bit          has_exp;
		segs_t       exp;
	} stim_row_t;

	logic clk;
	logic arst_n;

	arseg_in_if  in_ch ();
	arseg_out_if out_ch ();

	autorange_number_to_segments_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	segs_t     segs_due [$];     // predicted words, oldest first
	stim_row_t stim_rows [$];
	int        bad_words;        // mismatches plus unexpected words
	int        words_sent;
	int        cycle_cnt;
	bit        tail_calm;        // no idling on either side
	bit        squeeze_on;       // sink is holding off; source offers flat out

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [7:0] seg_for(input int unsigned d);
		return DIGIT_SEGS[d*8 +: 8];
	endfunction

	// Expected display for one word
	function automatic segs_t format_segments(input action_t act, input logic [23:0] val);
		logic [7:0]  s [4];
		int unsigned dig [6];
		int unsigned n;
		int unsigned rest;
		int unsigned used;
		int unsigned shift;
		int          dot;
		segs_t       r;
		n = {8'd0, val};
		if (act == ACT_TIME)
			n = n / 10;
		rest = n;
		for (int i = 0; i < 6; i++) begin
			dig[i] = rest % 10;
			rest   = rest / 10;
		end
		if (act == ACT_SPEED || act == ACT_TIME) begin
			// fixed point, zero padded; out of range reads 0000 with no dot
			if (n >= FIXED_LIMIT) begin
				for (int i = 0; i < 4; i++)
					s[i] = seg_for(0);
			end else begin
				shift = (n >= HUND_THOU) ? 2 : ((n >= TEN_THOU) ? 1 : 0);
				for (int i = 0; i < 4; i++)
					s[i] = seg_for(dig[i + shift]);
				dot = ((act == ACT_TIME) ? 2 : 3) - int'(shift);
				s[dot][SEG_DOT_BIT] = 1'b0;
			end
		end else begin
			// plain and the spare code: blanked leading digits, clamp at 9999
			if (n > PLAIN_LIMIT) begin
				for (int i = 0; i < 4; i++)
					s[i] = seg_for(9);
			end else begin
				used = (n >= 1000) ? 4 : ((n >= 100) ? 3 : ((n >= 10) ? 2 : 1));
				for (int i = 0; i < 4; i++)
					s[i] = (i < used) ? seg_for(dig[i]) : SEG_BLANK;
			end
		end
		r.rightmost = s[0];
		r.second    = s[1];
		r.third     = s[2];
		r.leftmost  = s[3];
		return r;
	endfunction

	task automatic add_row(input action_t a, input logic [23:0] v, input bit h,
		input segs_t e);
		stim_row_t row;
		row.act     = a;
		row.val     = v;
		row.has_exp = h;
		row.exp     = e;
		stim_rows.push_back(row);
	endtask

	// Sink side: random stall bursts, one long hold-off to back the pipe up
	initial begin : sink_side
		int hold_left;
		int stall_left;
		int sink_mode;
		int mode_age;
		bit squeeze_done;
		hold_left    = 0;
		stall_left   = 0;
		sink_mode    = 0;
		mode_age     = 0;
		squeeze_done = 1'b0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (!squeeze_done && words_sent >= SQUEEZE_AT) begin
				// long hold-off, counted here while the source keeps offering
				squeeze_done = 1'b1;
				squeeze_on   = 1'b1;
				hold_left    = SQUEEZE_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				squeeze_on = 1'b0;
				if (mode_age == 0) begin
					sink_mode = $urandom_range(0, 2);   // none, sparse, busy
					mode_age  = 64;
				end else begin
					mode_age--;
				end
				if (stall_left > 0) begin
					stall_left--;
					out_ch.ready <= 1'b0;
				end else if (!tail_calm && sink_mode != 0 &&
					$urandom_range(0, (sink_mode == 1) ? 7 : 2) == 0) begin
					stall_left   = $urandom_range(0, 5);
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Output check against the oldest prediction
	always @(posedge clk) begin
		segs_t got;
		segs_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.rightmost = out_ch.seg_rightmost;
			got.second    = out_ch.seg_second;
			got.third     = out_ch.seg_third;
			got.leftmost  = out_ch.seg_leftmost;
			if (segs_due.size() == 0) begin
				bad_words++;
				if (bad_words <= REPORT_MAX)
					$display("%0t: unexpected word %h %h %h %h (left to right)", $realtime,
						got.leftmost, got.third, got.second, got.rightmost);
			end else begin
				want = segs_due.pop_front();
				if (got.rightmost !== want.rightmost || got.second !== want.second ||
					got.third !== want.third || got.leftmost !== want.leftmost) begin
					bad_words++;
					if (bad_words <= REPORT_MAX)
						$display("%0t: mismatch, expected %h %h %h %h got %h %h %h %h",
							$realtime, want.leftmost, want.third, want.second,
							want.rightmost, got.leftmost, got.third, got.second,
							got.rightmost);
				end
			end
		end
	end

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Source side and run control
	initial begin : source_side
		int          total;
		int          gap;
		int          feed_mode;
		int          pick;
		int          near;
		action_t     act;
		logic [23:0] val;
		segs_t       due;
		bad_words  = 0;
		words_sent = 0;
		tail_calm  = 1'b0;
		squeeze_on = 1'b0;
		feed_mode  = 0;
		arst_n        = 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.action <= ACT_PLAIN;
		in_ch.value  <= '0;

		// extremes and range edges; known answers where obvious
		add_row(ACT_PLAIN, 24'd0,        1, 32'hFFFF_FF14);
		add_row(ACT_PLAIN, 24'd9999,     1, 32'h5050_5050);
		add_row(ACT_PLAIN, 24'd10000,    1, 32'h5050_5050);   // clamps
		add_row(ACT_PLAIN, 24'hFFFFFF,   1, 32'h5050_5050);
		add_row(ACT_SPEED, 24'd0,        1, 32'h0414_1414);
		add_row(ACT_SPEED, 24'd999999,   1, 32'h5050_4050);
		add_row(ACT_SPEED, 24'd1000000,  1, 32'h1414_1414);   // too large
		add_row(ACT_SPEED, 24'hFFFFFF,   1, 32'h1414_1414);
		add_row(ACT_TIME,  24'd0,        1, 32'h1404_1414);
		add_row(ACT_TIME,  24'd10000000, 1, 32'h1414_1414);   // n hits a million
		add_row(ACT_TIME,  24'hFFFFFF,   1, 32'h1414_1414);
		add_row(ACT_SPARE, 24'd0,        1, 32'hFFFF_FF14);   // spare code acts plain
		add_row(ACT_PLAIN, 24'd7,        0, '0);
		add_row(ACT_PLAIN, 24'd10,       0, '0);
		add_row(ACT_PLAIN, 24'd99,       0, '0);
		add_row(ACT_PLAIN, 24'd100,      0, '0);
		add_row(ACT_PLAIN, 24'd1234,     0, '0);
		add_row(ACT_SPEED, 24'd9999,     0, '0);
		add_row(ACT_SPEED, 24'd10000,    0, '0);
		add_row(ACT_SPEED, 24'd99999,    0, '0);
		add_row(ACT_SPEED, 24'd100000,   0, '0);
		add_row(ACT_TIME,  24'd99999,    0, '0);
		add_row(ACT_TIME,  24'd100009,   0, '0);
		add_row(ACT_TIME,  24'd9999999,  0, '0);
		add_row(ACT_SPARE, 24'd99999,    0, '0);

		total = stim_rows.size() + RAND_WORDS;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < total; i++) begin
			if (i < stim_rows.size()) begin
				act = stim_rows[i].act;
				val = stim_rows[i].val;
			end else begin
				act  = action_t'($urandom_range(0, 3));
				pick = $urandom_range(0, 7);
				case (pick)
					0: val = 24'($urandom_range(0, 9999));
					1: val = 24'($urandom_range(10000, 99999));
					2: val = 24'($urandom_range(100000, 999999));
					3: val = 24'($urandom_range(1000000, 10000999));
					4: val = 24'($urandom_range(0, 120));
					5: begin
						// hug a range edge
						case ($urandom_range(0, 9))
							0: near = 9;
							1: near = 99;
							2: near = 999;
							3: near = 9999;
							4: near = 99999;
							5: near = 999999;
							6: near = 9999999;
							7: near = 99999 * 10 + 9;
							8: near = 16777215;
							default: near = 0;
						endcase
						near = near + int'($urandom_range(0, 4)) - 2;
						if (near < 0)
							near = 0;
						if (near > 16777215)
							near = 16777215;
						val = 24'(near);
					end
					default: val = 24'($urandom());
				endcase
			end

			tail_calm = (i >= total - TAIL_WORDS);
			if (i % 40 == 0)
				feed_mode = $urandom_range(0, 2);
			gap = 0;
			if (!tail_calm && !squeeze_on && feed_mode != 0 &&
				$urandom_range(0, (feed_mode == 1) ? 5 : 1) == 0)
				gap = $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_ch.valid  <= 1'b1;
			in_ch.action <= act;
			in_ch.value  <= val;
			do
				@(posedge clk);
			while (!in_ch.ready);

			// word taken at this edge
			if (i < stim_rows.size() && stim_rows[i].has_exp)
				due = stim_rows[i].exp;
			else
				due = format_segments(act, val);
			segs_due.push_back(due);
			words_sent++;
		end
		in_ch.valid <= 1'b0;

		while (segs_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_words == 0 && segs_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
